### src/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam logic [15:0] MAX_BYTES_RESET = 16'hFFFF;

    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_PAD     = 8'd61;

    localparam logic [7:0] LOWER_OFFSET = 8'd71;
    localparam logic [7:0] DIGIT_OFFSET = 8'd4;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [1:0] BYTES_PER_GROUP = 2'd3;
    localparam logic [1:0] LAST_GROUP_POS  = 2'd3;

    // decoded results of one character: up to three bytes of one group
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbyte;
        logic [1:0]  nres;
        logic        bad_char;
        logic        bad_len;
    } t_batch;

    // {valid, sextet}
    function automatic logic [6:0] f_sextet(input logic [7:0] ch);
        logic [6:0] r;
        r = '0;
        unique case (ch) inside
            [CH_UPPER_A:CH_UPPER_Z]: r = {1'b1, 6'(ch - CH_UPPER_A)};
            [CH_LOWER_A:CH_LOWER_Z]: r = {1'b1, 6'(ch - LOWER_OFFSET)};
            [CH_DIGIT_0:CH_DIGIT_9]: r = {1'b1, 6'(ch + DIGIT_OFFSET)};
            CH_PLUS:                 r = {1'b1, SEXTET_PLUS};
            CH_SLASH:                r = {1'b1, SEXTET_SLASH};
            CH_PAD:                  r = {1'b1, 6'd0};
            default:                 r = '0;
        endcase
        return r;
    endfunction

endpackage

### src/base64_stream_decoder.sv
`timescale 1ns / 1ps
// Path: a character accepted into the input register is decoded into the result
// register once that register is free; its first result is presented from there.
// Throughput: one character per cycle while i_stall is low; a group with several
// results holds the input until its last is taken, draining one result per unstalled cycle.
// Reset (synchronous, active low): clears group state, counters, results; max_bytes=65535.

module base64_stream_decoder #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    input  logic        i_max_bytes_we,
    input  logic [15:0] i_max_bytes_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_run,
    output logic        o_bad_char,
    output logic        o_bad_length,
    output logic [15:0] o_bytes_written
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_eos;
    logic [15:0] r_max_bytes;

    logic                  take;
    logic                  fire;
    logic                  load;
    b64d_pkg::t_batch      batch;
    logic [COUNT_BITS-1:0] base;

    assign fire    = r_in_valid && take;
    assign o_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_max_bytes <= b64d_pkg::MAX_BYTES_RESET;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (i_max_bytes_we) begin
                r_max_bytes <= i_max_bytes_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_char_code;
            r_in_eos  <= i_end_of_string;
        end
    end

    b64d_group #(
        .COUNT_BITS (COUNT_BITS)
    ) u_group (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_char_code     (r_in_char),
        .i_end_of_string (r_in_eos),
        .i_max_bytes     (r_max_bytes),
        .o_load          (load),
        .o_batch         (batch),
        .o_base          (base)
    );

    b64d_out #(
        .COUNT_BITS (COUNT_BITS)
    ) u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_batch         (batch),
        .i_base          (base),
        .i_stall         (i_stall),
        .o_take          (take),
        .o_valid         (o_valid),
        .o_data_byte     (o_data_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_run   (o_last_of_run),
        .o_bad_char      (o_bad_char),
        .o_bad_length    (o_bad_length),
        .o_bytes_written (o_bytes_written)
    );

endmodule

### src/b64d_group.sv
`timescale 1ns / 1ps

module b64d_group #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_char_code,
    input  logic                   i_end_of_string,
    input  logic [15:0]            i_max_bytes,
    output logic                   o_load,
    output b64d_pkg::t_batch       o_batch,
    output logic [COUNT_BITS-1:0]  o_base
);

    localparam logic [31:0] CountMask = 32'((64'd1 << COUNT_BITS) - 64'd1);

    logic [17:0]           r_bits,  n_bits;
    logic [1:0]            r_pos,   n_pos;
    logic [2:0]            r_pad,   n_pad;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic                  r_bcs,   n_bcs;

    logic [6:0]  sx;
    logic        is_pad;
    logic [2:0]  pad_n;
    logic        full;
    logic [1:0]  cnt;
    logic [31:0] lim32;
    logic [31:0] tot32;
    logic [31:0] avail32;
    logic [1:0]  nb;
    logic        bc;

    always_comb begin
        sx      = b64d_pkg::f_sextet(i_char_code);
        is_pad  = (i_char_code == b64d_pkg::CH_PAD);
        pad_n   = r_pad + 3'(is_pad);
        full    = (r_pos == b64d_pkg::LAST_GROUP_POS);
        cnt     = (pad_n <= 3'(b64d_pkg::BYTES_PER_GROUP)) ?
                  2'(3'(b64d_pkg::BYTES_PER_GROUP) - pad_n) : 2'd0;
        lim32   = (32'(i_max_bytes) < CountMask) ? 32'(i_max_bytes) : CountMask;
        tot32   = 32'(r_total);
        avail32 = (tot32 >= lim32) ? 32'd0 : (lim32 - tot32);
        if (!full) begin
            nb = 2'd0;
        end else if (avail32 >= 32'(cnt)) begin
            nb = cnt;
        end else begin
            nb = avail32[1:0];
        end
        bc = r_bcs | ~sx[6];

        o_batch.word     = {r_bits, sx[5:0]};
        o_batch.nbyte    = nb;
        o_batch.nres     = (nb != 2'd0) ? nb : (i_end_of_string ? 2'd1 : 2'd0);
        o_batch.bad_char = bc;
        o_batch.bad_len  = i_end_of_string && !full;
        o_base           = r_total;
        o_load           = i_fire && (o_batch.nres != 2'd0);
    end

    always_comb begin
        n_bits  = r_bits;
        n_pos   = r_pos;
        n_pad   = r_pad;
        n_total = r_total;
        n_bcs   = r_bcs;
        if (i_fire) begin
            if (i_end_of_string) begin
                n_bits  = '0;
                n_pos   = '0;
                n_pad   = '0;
                n_total = '0;
                n_bcs   = 1'b0;
            end else if (full) begin
                n_bits  = '0;
                n_pos   = '0;
                n_pad   = '0;
                n_total = r_total + COUNT_BITS'(nb);
                n_bcs   = bc;
            end else begin
                n_bits  = {r_bits[11:0], sx[5:0]};
                n_pos   = r_pos + 2'd1;
                n_pad   = pad_n;
                n_bcs   = bc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_pos   <= '0;
            r_pad   <= '0;
            r_total <= '0;
            r_bcs   <= 1'b0;
        end else begin
            r_bits  <= n_bits;
            r_pos   <= n_pos;
            r_pad   <= n_pad;
            r_total <= n_total;
            r_bcs   <= n_bcs;
        end
    end

    // pads are counted only among the characters held in the group
    a_pad_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad <= {1'b0, r_pos})
        else $error("pad count exceeds group position");

endmodule

### src/b64d_out.sv
`timescale 1ns / 1ps

module b64d_out #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  b64d_pkg::t_batch       i_batch,
    input  logic [COUNT_BITS-1:0]  i_base,
    input  logic                   i_stall,
    output logic                   o_take,
    output logic                   o_valid,
    output logic [7:0]             o_data_byte,
    output logic                   o_byte_valid,
    output logic                   o_last_of_run,
    output logic                   o_bad_char,
    output logic                   o_bad_length,
    output logic [15:0]            o_bytes_written
);

    b64d_pkg::t_batch       r_batch;
    logic [COUNT_BITS-1:0]  r_base;
    logic [1:0]             r_pos,  n_pos;
    logic [1:0]             r_left, n_left;

    logic                  pop;
    logic [7:0]            sel_byte;
    logic [COUNT_BITS-1:0] written;
    logic [31:0]           written32;

    always_comb begin
        o_valid       = (r_left != 2'd0);
        o_last_of_run = (r_left == 2'd1);
        pop           = o_valid && !i_stall;
        o_take        = !o_valid || (o_last_of_run && !i_stall);
        o_byte_valid  = o_valid && (r_pos < r_batch.nbyte);
        case (r_pos)
            2'd0:    sel_byte = r_batch.word[23:16];
            2'd1:    sel_byte = r_batch.word[15:8];
            default: sel_byte = r_batch.word[7:0];
        endcase
        o_data_byte     = o_byte_valid ? sel_byte : 8'd0;
        o_bad_char      = r_batch.bad_char;
        o_bad_length    = r_batch.bad_len && o_last_of_run;
        written         = r_base + (o_byte_valid ? COUNT_BITS'(r_pos) + COUNT_BITS'(1)
                                                 : COUNT_BITS'(0));
        written32       = 32'(written);
        o_bytes_written = written32[15:0];
    end

    always_comb begin
        n_pos  = r_pos;
        n_left = r_left;
        if (i_load) begin
            n_pos  = 2'd0;
            n_left = i_batch.nres;
        end else if (pop) begin
            n_pos  = r_pos + 2'd1;
            n_left = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_left <= '0;
        end else begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
            r_base  <= i_base;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!o_valid || (o_last_of_run && !i_stall)))
        else $error("batch loaded over pending results");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> o_last_of_run)
        else $error("status-only result not last of run");

    a_badlen_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bad_length |-> (o_valid && o_last_of_run))
        else $error("bad length outside last result");

endmodule

### sim/base64_stream_decoder_test.sv
`timescale 1ns / 1ps

module base64_stream_decoder_test;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last_of_run;
        logic        bad_char;
        logic        bad_length;
        logic [15:0] bytes_written;
    } t_decoded;

    class b64_group_decoder;
        bit [15:0] max_bytes;
        bit [17:0] group_bits;
        bit [1:0]  group_pos;
        bit [2:0]  pad_count;
        bit [15:0] byte_total;
        bit        bad_seen;
        t_decoded  pending_bytes[$];
        int        errors;

        function new();
            max_bytes  = b64d_pkg::MAX_BYTES_RESET;
            group_bits = '0;
            group_pos  = '0;
            pad_count  = '0;
            byte_total = '0;
            bad_seen   = 1'b0;
            errors     = 0;
        endfunction

        function void set_limit(bit [15:0] v);
            max_bytes = v;
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction

        function void take_char(bit [7:0] ch, bit eos);
            t_decoded  batch[3];
            int        n;
            bit [5:0]  v;
            bit        ok;
            bit [23:0] word;
            int        cnt;
            n  = 0;
            ok = 1'b1;
            v  = '0;
            if (ch >= b64d_pkg::CH_UPPER_A && ch <= b64d_pkg::CH_UPPER_Z) begin
                v = 6'(ch - b64d_pkg::CH_UPPER_A);
            end else if (ch >= b64d_pkg::CH_LOWER_A && ch <= b64d_pkg::CH_LOWER_Z) begin
                v = 6'(ch - b64d_pkg::LOWER_OFFSET);
            end else if (ch >= b64d_pkg::CH_DIGIT_0 && ch <= b64d_pkg::CH_DIGIT_9) begin
                v = 6'(ch + b64d_pkg::DIGIT_OFFSET);
            end else if (ch == b64d_pkg::CH_PLUS) begin
                v = b64d_pkg::SEXTET_PLUS;
            end else if (ch == b64d_pkg::CH_SLASH) begin
                v = b64d_pkg::SEXTET_SLASH;
            end else if (ch != b64d_pkg::CH_PAD) begin
                ok = 1'b0;
            end
            if (!ok) bad_seen = 1'b1;
            if (ch == b64d_pkg::CH_PAD) pad_count = pad_count + 3'd1;

            if (group_pos != b64d_pkg::LAST_GROUP_POS) begin
                group_bits = {group_bits[11:0], v};
                group_pos  = group_pos + 2'd1;
            end else begin
                word = {group_bits, v};
                cnt  = (pad_count <= 3) ? 3 - pad_count : 0;
                for (int i = 0; i < cnt; i++) begin
                    if (byte_total >= max_bytes || byte_total == 16'hFFFF) break;
                    byte_total = byte_total + 16'd1;
                    batch[n].data_byte     = word[23:16];
                    batch[n].byte_valid    = 1'b1;
                    batch[n].last_of_run   = 1'b0;
                    batch[n].bad_char      = bad_seen;
                    batch[n].bad_length    = 1'b0;
                    batch[n].bytes_written = byte_total;
                    n++;
                    word = word << 8;
                end
                group_bits = '0;
                group_pos  = '0;
                pad_count  = '0;
            end

            if (eos) begin
                if (n == 0) begin
                    batch[0].data_byte     = '0;
                    batch[0].byte_valid    = 1'b0;
                    batch[0].last_of_run   = 1'b0;
                    batch[0].bad_char      = bad_seen;
                    batch[0].bytes_written = byte_total;
                    n = 1;
                end
                batch[n-1].bad_length = (group_pos != 0);
            end
            if (n > 0) batch[n-1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++) pending_bytes.push_back(batch[i]);

            if (eos) begin
                group_bits = '0;
                group_pos  = '0;
                pad_count  = '0;
                byte_total = '0;
                bad_seen   = 1'b0;
            end
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_byte(t_decoded got);
            t_decoded want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: data_byte %0d bytes_written %0d",
                       got.data_byte, got.bytes_written);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            cmp_field("data_byte", want.data_byte, got.data_byte);
            cmp_field("byte_valid", want.byte_valid, got.byte_valid);
            cmp_field("last_of_run", want.last_of_run, got.last_of_run);
            cmp_field("bad_char", want.bad_char, got.bad_char);
            cmp_field("bad_length", want.bad_length, got.bad_length);
            cmp_field("bytes_written", want.bytes_written, got.bytes_written);
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_code;
    logic        i_end_of_string;
    logic        i_max_bytes_we;
    logic [15:0] i_max_bytes_wdata;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_byte_valid;
    logic        o_last_of_run;
    logic        o_bad_char;
    logic        o_bad_length;
    logic [15:0] o_bytes_written;

    b64_group_decoder decoder;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int chars_sent    = 0;
    int quiet_cycles  = 0;

    base64_stream_decoder u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_char_code       (i_char_code),
        .i_end_of_string   (i_end_of_string),
        .i_max_bytes_we    (i_max_bytes_we),
        .i_max_bytes_wdata (i_max_bytes_wdata),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_data_byte       (o_data_byte),
        .o_byte_valid      (o_byte_valid),
        .o_last_of_run     (o_last_of_run),
        .o_bad_char        (o_bad_char),
        .o_bad_length      (o_bad_length),
        .o_bytes_written   (o_bytes_written)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    always @(posedge i_clk) begin
        t_decoded got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.data_byte     = o_data_byte;
            got.byte_valid    = o_byte_valid;
            got.last_of_run   = o_last_of_run;
            got.bad_char      = o_bad_char;
            got.bad_length    = o_bad_length;
            got.bytes_written = o_bytes_written;
            decoder.match_byte(got);
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_max_bytes_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eos);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_char_code     <= ch;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_stall);
        decoder.take_char(ch, eos);
        chars_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_b64_char();
        int idx;
        idx = $urandom_range(63);
        if (idx < 26) return b64d_pkg::CH_UPPER_A + 8'(idx);
        if (idx < 52) return b64d_pkg::CH_LOWER_A + 8'(idx - 26);
        if (idx < 62) return b64d_pkg::CH_DIGIT_0 + 8'(idx - 52);
        return (idx == 62) ? b64d_pkg::CH_PLUS : b64d_pkg::CH_SLASH;
    endfunction

    task automatic send_random_string();
        logic [7:0] chars[$];
        int         groups;
        int         pads;
        int         len;
        int         pick;
        if ($urandom_range(99) < 75) begin
            groups = $urandom_range(1, 3);
            pads   = $urandom_range(0, 2);
            for (int i = 0; i < groups * 4; i++) begin
                chars.push_back((i >= groups * 4 - pads) ? b64d_pkg::CH_PAD
                                                         : rand_b64_char());
            end
        end else begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(3);
                if (pick < 2) chars.push_back(8'($urandom_range(255)));
                else if (pick == 2) chars.push_back(b64d_pkg::CH_PAD);
                else chars.push_back(rand_b64_char());
            end
        end
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    // sender holds off until every expected transaction is out
    task automatic drain();
        i_valid <= 1'b0;
        while (decoder.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        drain();
        i_max_bytes_we    <= 1'b1;
        i_max_bytes_wdata <= v;
        @(posedge i_clk);
        decoder.set_limit(v);
        i_max_bytes_we    <= 1'b0;
    endtask

    task automatic run_phase(input int src, input int snk, input logic [15:0] limit,
                             input int n);
        int stop_at;
        write_limit(limit);
        src_idle_pct  = src;
        snk_stall_pct = snk;
        stop_at = chars_sent + n;
        while (chars_sent < stop_at) send_random_string();
    endtask

    initial begin
        decoder = new();
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_char_code       <= '0;
        i_end_of_string   <= 1'b0;
        i_max_bytes_we    <= 1'b0;
        i_max_bytes_wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_string("TWFu");
        send_string("TQ==");
        send_string("+/9zaZ0A");
        send_string("@");
        send_string("====");
        send_char(8'h00, 1'b0);
        send_char(b64d_pkg::CH_PAD, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(b64d_pkg::CH_LOWER_Z, 1'b1);

        run_phase(0, 0, 16'd0, 50);
        run_phase(83, 0, 16'($urandom_range(1, 8)), 50);
        run_phase(0, 83, 16'hFFFF, 50);
        run_phase(26, 26, 16'd3, 50);
        run_phase(0, 0, 16'($urandom_range(0, 65535)), 40);
        run_phase(26, 26, 16'd1, 40);

        drain();
        repeat (10) @(posedge i_clk);
        if (decoder.errors == 0 && decoder.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
src/b64d_pkg.sv
src/b64d_group.sv
src/b64d_out.sv
src/base64_stream_decoder.sv
sim/base64_stream_decoder_test.sv
